@@ src/ckpb_pkg.sv @@
// Shared types, constants and helper functions of the chroma-key pixel blender.
package ckpb_pkg;

  // Pixel channel and register widths.
  localparam int unsigned CH_W      = 8;
  localparam int unsigned MIX_W     = 9;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned ALPHA_W   = 9;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;

  // Offset square, sum of squares and square root widths.
  localparam int unsigned OFF_W     = 10;
  localparam int unsigned OSQ_W     = 17;
  localparam int unsigned SUM_W     = 18;
  localparam int unsigned SQ_DIGITS = 25;
  localparam int unsigned SQ_S_DIGITS = SUM_W / 2;
  localparam int unsigned ROOT_W    = SQ_DIGITS;
  localparam int unsigned REM_W     = ROOT_W + 1;

  // Product, distance, cube and blend widths; distance, square and cube have 16 fraction bits.
  localparam int unsigned PROD_W    = ROOT_W + GAIN_W;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned DSQ_W     = 19;
  localparam int unsigned CUBE_W    = 20;
  localparam int unsigned MIXQ_W    = MIX_W + 8;
  localparam int unsigned BLEND_W   = 17;

  localparam logic [DIST_W-1:0]  DIST_SAT  = DIST_W'(1 << 17);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(256);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(256);

  // Register map, one register per 32-bit word.
  typedef enum logic [2:0] {
    REG_KEY_RED   = 3'd0,
    REG_KEY_GREEN = 3'd1,
    REG_KEY_BLUE  = 3'd2,
    REG_MIX_LEVEL = 3'd3,
    REG_FADE_GAIN = 3'd4
  } reg_idx_t;

  // Source and background pixel carried down the pipeline.
  typedef struct packed {
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] dst_red;
    logic [CH_W-1:0] dst_green;
    logic [CH_W-1:0] dst_blue;
  } pix_t;

  // One finished result.
  typedef struct packed {
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [ALPHA_W-1:0] alpha;
  } res_t;

  // Square of the channel offset c - 256 + key, which lies in -256..254.
  function automatic logic [OSQ_W-1:0] offset_sq(input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] key);
    logic signed [OFF_W-1:0]   off;
    logic signed [2*OFF_W-1:0] prod;
    off  = signed'({2'b00, c}) + signed'({2'b00, key}) - OFF_W'(256);
    prod = off * off;
    return prod[OSQ_W-1:0];
  endfunction

  // One channel of the blend: (s*a + d*(256-a)) >> 8.
  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0]    s,
                                               input logic [CH_W-1:0]    d,
                                               input logic [ALPHA_W-1:0] a);
    logic [ALPHA_W-1:0] inv;
    logic [BLEND_W-1:0] acc;
    inv = ALPHA_MAX - a;
    acc = BLEND_W'(s) * BLEND_W'(a) + BLEND_W'(d) * BLEND_W'(inv);
    return acc[15:8];
  endfunction

endpackage

@@ src/chroma_key_pixel_blend.sv @@
// Chroma-key alpha blender: pipelined key distance, alpha and pixel mix.
//
// The input channel (in_valid / in_stall) takes one keyed source pixel and one
// background pixel per transfer. The result channel (out_valid / out_stall)
// returns the blended pixel and the alpha that was applied, one result per
// input, in order. An APB register port sets the key color, mix level and gain;
// the user must write it only while no pixel is in flight; nothing enforces it.
// Throughput is one pixel per clock while in_stall is low. Two stages form the
// sum of squared key offsets, the square root takes 25 stages at one result
// bit each, then one stage each for the gain product, saturation, square, cube
// and alpha, and the output register holds the blend.
// When the receiver stalls, the whole pipeline keeps moving until a one-entry
// skid register behind the output fills; in_stall is that skid flag, so it is
// a register, and the input keeps accepting until the skid register fills.
// Reset (rst_n low, synchronous) empties the pipeline and sets key = 0,
// mix_level = 0 and fade_gain = 256.
module chroma_key_pixel_blend (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_src_red,
  input  logic [7:0]  in_src_green,
  input  logic [7:0]  in_src_blue,
  input  logic [7:0]  in_dst_red,
  input  logic [7:0]  in_dst_green,
  input  logic [7:0]  in_dst_blue,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [8:0]  out_alpha_used,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ckpb_pkg::APB_AW-1:0] paddr,
  input  logic [ckpb_pkg::APB_DW-1:0] pwdata,
  output logic [ckpb_pkg::APB_DW-1:0] prdata,
  output logic        pready
);
  import ckpb_pkg::*;

  // Pipeline stage numbers.
  localparam int unsigned ST_SUM   = 1;
  localparam int unsigned ST_RT0   = ST_SUM + 1;
  localparam int unsigned ST_PROD  = ST_RT0 + SQ_DIGITS;
  localparam int unsigned ST_DIST  = ST_PROD + 1;
  localparam int unsigned ST_DSQ   = ST_DIST + 1;
  localparam int unsigned ST_CUBE  = ST_DSQ + 1;
  localparam int unsigned ST_ALPHA = ST_CUBE + 1;
  localparam int unsigned NST      = ST_ALPHA + 1;

  // Configuration registers.
  logic [CH_W-1:0]   key_red_r, key_green_r, key_blue_r;
  logic [MIX_W-1:0]  mix_level_r;
  logic [GAIN_W-1:0] fade_gain_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  // Pipeline state.
  logic              en;
  logic              vld_r [NST];
  pix_t              pix_r [NST];
  pix_t              pix_in;
  logic [OSQ_W-1:0]  osq_r [3];
  logic [SUM_W-1:0]  sum_r;
  logic [REM_W-1:0]  rt_rem_r  [SQ_DIGITS];
  logic [ROOT_W-1:0] rt_root_r [SQ_DIGITS];
  logic [SUM_W-1:0]  rt_s_r    [SQ_S_DIGITS-1];
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_full;
  logic [DIST_W-1:0] dist_r, dist_sq_r;
  logic [2*DIST_W-1:0] dsq_full;
  logic [DSQ_W-1:0]  dsq_r;
  logic [DSQ_W+DIST_W-1:0] cube_full;
  logic [CUBE_W-1:0] cube_r;
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  res_t              res_nxt;

  // Output register and skid register.
  logic              out_valid_r, sk_valid_r;
  res_t              out_res_r, sk_res_r;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Register writes; addresses past the map are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r   <= '0;
      key_green_r <= '0;
      key_blue_r  <= '0;
      mix_level_r <= '0;
      fade_gain_r <= GAIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY_RED:   key_red_r   <= pwdata[CH_W-1:0];
        REG_KEY_GREEN: key_green_r <= pwdata[CH_W-1:0];
        REG_KEY_BLUE:  key_blue_r  <= pwdata[CH_W-1:0];
        REG_MIX_LEVEL: mix_level_r <= pwdata[MIX_W-1:0];
        REG_FADE_GAIN: fade_gain_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_idx)
      REG_KEY_RED:   prdata = APB_DW'(key_red_r);
      REG_KEY_GREEN: prdata = APB_DW'(key_green_r);
      REG_KEY_BLUE:  prdata = APB_DW'(key_blue_r);
      REG_MIX_LEVEL: prdata = APB_DW'(mix_level_r);
      REG_FADE_GAIN: prdata = APB_DW'(fade_gain_r);
      default:       prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ flow control
  // Every stage advances together unless the skid register is holding a result.
  assign en       = !sk_valid_r;
  assign in_stall = sk_valid_r;

  assign pix_in = '{src_red: in_src_red, src_green: in_src_green, src_blue: in_src_blue,
                    dst_red: in_dst_red, dst_green: in_dst_green, dst_blue: in_dst_blue};

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // The pixel pair rides along for the final blend.
  always_ff @(posedge clk) begin
    if (en) begin
      pix_r[0] <= pix_in;
      for (int k = 1; k < NST; k++) begin
        pix_r[k] <= pix_r[k-1];
      end
    end
  end

  // ------------------------------------------------- key offsets and their sum
  always_ff @(posedge clk) begin
    if (en) begin
      osq_r[0] <= offset_sq(in_src_red, key_red_r);
      osq_r[1] <= offset_sq(in_src_green, key_green_r);
      osq_r[2] <= offset_sq(in_src_blue, key_blue_r);
      sum_r    <= SUM_W'(osq_r[0]) + SUM_W'(osq_r[1]) + SUM_W'(osq_r[2]);
    end
  end

  // --------------------------------------------------------------- square root
  // Digit-by-digit root of sum << 32, one result bit per stage. The low 16 digit
  // pairs of the radicand are zero; the upper nine come from the sum.
  for (genvar j = 0; j < SQ_DIGITS; j++) begin : g_rt
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [1:0]        pair;
    logic [REM_W+1:0]  shifted, trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign pair    = sum_r[2*(SQ_S_DIGITS-1)+1 -: 2];
    end else begin : g_next
      assign rem_in  = rt_rem_r[j-1];
      assign root_in = rt_root_r[j-1];
      if (j < SQ_S_DIGITS) begin : g_pair
        assign pair = rt_s_r[j-1][2*(SQ_S_DIGITS-1-j)+1 -: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end
    end

    assign shifted = {rem_in, pair};
    assign trial   = {1'b0, root_in, 2'b01};

    // Keep the trial subtraction when it fits and set this root bit.
    always_comb begin
      if (shifted >= trial) begin
        rem_nxt  = REM_W'(shifted - trial);
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[REM_W-1:0];
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_rem_r[j]  <= rem_nxt;
        rt_root_r[j] <= root_nxt;
      end
    end

    // The sum is carried only as far as its digits are still needed.
    if (j < SQ_S_DIGITS - 1) begin : g_s
      always_ff @(posedge clk) begin
        if (en) begin
          rt_s_r[j] <= (j == 0) ? sum_r : rt_s_r[(j == 0) ? 0 : j-1];
        end
      end
    end
  end

  // ------------------------------------------------------- distance and cube
  // Full-width products; each stage keeps only the bits that it needs.
  assign prod_full = rt_root_r[SQ_DIGITS-1] * fade_gain_r;
  assign dsq_full  = dist_r * dist_r;
  assign cube_full = dsq_r * dist_sq_r;

  // Gain product, then saturation at 2.0, then square and cube in Q16.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r      <= prod_full;
      dist_r      <= (prod_r[PROD_W-1:15] > (PROD_W-15)'(DIST_SAT)) ?
                     DIST_SAT : prod_r[15+DIST_W-1:15];
      dsq_r       <= dsq_full[16 +: DSQ_W];
      dist_sq_r   <= dist_r;
      cube_r      <= cube_full[16 +: CUBE_W];
      alpha_r     <= alpha_nxt;
    end
  end

  // Alpha: (mix - cube) truncated to 8 fraction bits, clamped to 0..256.
  always_comb begin
    logic [MIXQ_W-1:0] mixq;
    logic [MIXQ_W-1:0] diff;
    mixq = {mix_level_r, 8'h00};
    diff = mixq - MIXQ_W'(cube_r);
    if (MIXQ_W'(cube_r) >= mixq || cube_r[CUBE_W-1:MIXQ_W] != '0) begin
      alpha_nxt = '0;
    end else if (diff[MIXQ_W-1:8] > ALPHA_MAX) begin
      alpha_nxt = ALPHA_MAX;
    end else begin
      alpha_nxt = diff[MIXQ_W-1:8];
    end
  end

  // --------------------------------------------------------- blend and output
  always_comb begin
    res_nxt.red   = blend_ch(pix_r[ST_ALPHA].src_red,   pix_r[ST_ALPHA].dst_red,   alpha_r);
    res_nxt.green = blend_ch(pix_r[ST_ALPHA].src_green, pix_r[ST_ALPHA].dst_green, alpha_r);
    res_nxt.blue  = blend_ch(pix_r[ST_ALPHA].src_blue,  pix_r[ST_ALPHA].dst_blue,  alpha_r);
    res_nxt.alpha = alpha_r;
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (en && vld_r[ST_ALPHA]) begin
        sk_valid_r <= 1'b1;
      end
    end else if (sk_valid_r) begin
      out_valid_r <= 1'b1;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= vld_r[ST_ALPHA];
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (en && vld_r[ST_ALPHA]) begin
        sk_res_r <= res_nxt;
      end
    end else if (sk_valid_r) begin
      out_res_r <= sk_res_r;
    end else begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_res_r.red;
  assign out_green      = out_res_r.green;
  assign out_blue       = out_res_r.blue;
  assign out_alpha_used = out_res_r.alpha;

  // --------------------------------------------------------------- assertions
  // A held skid result always sits behind a valid output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid register full while output register is empty");

  // The skid only fills while the output is stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without an output stall");

  // Once the output drains, the skid result moves up and the skid empties.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_valid_r && !out_stall) |=> (out_valid_r && !sk_valid_r))
    else $error("skid register did not drain into the output register");

  // Saturated distance never exceeds 2.0.
  a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_DIST] |-> (dist_r <= DIST_SAT))
    else $error("distance above saturation limit");

  // Alpha stays within 0..256.
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_ALPHA] |-> (alpha_r <= ALPHA_MAX))
    else $error("alpha above 256");

endmodule
